FILE: sv/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants of the 64-bit Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned MaxBases = 12;
  localparam int unsigned BaseIdxW = 4;
  localparam int unsigned BitIdxW = 6;
  localparam int unsigned TwosW = 6;

  typedef logic [DataW-1:0] word_t;

  // Witness bases, fixed.
  function automatic logic [5:0] witness_base(input logic [BaseIdxW-1:0] idx);
    logic [5:0] b;
    case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd37;
    endcase
    return b;
  endfunction

  // Datapath commands from the controller.
  typedef enum logic [2:0] {
    CmdNone,
    CmdLoad,      // capture candidate, set d = n - 1
    CmdShift,     // d >>= 1, twos++
    CmdInitBase,  // x = 1, b = base, e = d
    CmdMulStart,  // begin x*b (sel=0) or b*b (sel=1) or x*x (sel=2)
    CmdMulStep,   // one double-and-add step
    CmdMulDone,   // write product back
    CmdExpShift   // e >>= 1
  } cmd_e;

  typedef enum logic [1:0] {
    SelXB,
    SelBB,
    SelXX
  } sel_e;

  typedef struct packed {
    cmd_e                cmd;
    sel_e                sel;
    logic [BaseIdxW-1:0] base_idx;
  } ctrl_t;

  typedef struct packed {
    logic d_odd;
    logic e_zero;
    logic e_lsb;
    logic mul_last;
    logic x_one;
    logic x_m1;
    logic small_comp;
    logic small_prime;
    logic base_ge_n;
    logic [TwosW-1:0] twos;
  } stat_t;

endpackage

FILE: sv/mrpt_datapath.sv
// ----------------------------------------------------------------------------
// mrpt_datapath
// Candidate, exponent and residue registers with a bit-serial modular
// multiplier that handles one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mrpt_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mrpt_pkg::word_t candidate_i,
  input  mrpt_pkg::ctrl_t ctrl_i,
  output mrpt_pkg::stat_t stat_o
);

  mrpt_pkg::word_t n_q, n_d, d_q, d_d, e_q, e_d, x_q, x_d, b_q, b_d;
  mrpt_pkg::word_t acc_q, acc_d, ma_q, ma_d, mb_q, mb_d;
  logic [mrpt_pkg::BitIdxW-1:0] bit_q, bit_d;
  logic [mrpt_pkg::TwosW-1:0] twos_q, twos_d;
  mrpt_pkg::word_t dbl, nxt;
  logic [mrpt_pkg::DataW:0] s1, s2;
  mrpt_pkg::word_t base_w;

  // Modular double, then modular add of the multiplicand when the bit is set.
  always_comb begin
    s1 = {1'b0, acc_q} + {1'b0, acc_q};
    if (s1 >= {1'b0, n_q}) s1 = s1 - {1'b0, n_q};
    dbl = s1[mrpt_pkg::DataW-1:0];
    s2 = {1'b0, dbl} + {1'b0, ma_q};
    if (s2 >= {1'b0, n_q}) s2 = s2 - {1'b0, n_q};
    nxt = mb_q[bit_q] ? s2[mrpt_pkg::DataW-1:0] : dbl;
  end

  assign base_w = {58'd0, mrpt_pkg::witness_base(ctrl_i.base_idx)};

  always_comb begin
    n_d = n_q; d_d = d_q; e_d = e_q; x_d = x_q; b_d = b_q;
    acc_d = acc_q; ma_d = ma_q; mb_d = mb_q; bit_d = bit_q; twos_d = twos_q;
    unique case (ctrl_i.cmd)
      mrpt_pkg::CmdLoad: begin
        n_d = candidate_i; d_d = candidate_i - 64'd1; twos_d = '0;
      end
      mrpt_pkg::CmdShift: begin
        d_d = d_q >> 1; twos_d = twos_q + 1'b1;
      end
      mrpt_pkg::CmdInitBase: begin
        x_d = 64'd1; b_d = base_w; e_d = d_q;
      end
      mrpt_pkg::CmdMulStart: begin
        acc_d = '0; bit_d = '1;
        unique case (ctrl_i.sel)
          mrpt_pkg::SelXB: begin ma_d = x_q; mb_d = b_q; end
          mrpt_pkg::SelBB: begin ma_d = b_q; mb_d = b_q; end
          default:         begin ma_d = x_q; mb_d = x_q; end
        endcase
      end
      mrpt_pkg::CmdMulStep: begin
        acc_d = nxt; bit_d = bit_q - 1'b1;
      end
      mrpt_pkg::CmdMulDone: begin
        if (ctrl_i.sel == mrpt_pkg::SelBB) b_d = acc_q;
        else x_d = acc_q;
      end
      mrpt_pkg::CmdExpShift: e_d = e_q >> 1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
      twos_q <= '0;
    end else begin
      bit_q <= bit_d;
      twos_q <= twos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; e_q <= e_d; x_q <= x_d; b_q <= b_d;
    acc_q <= acc_d; ma_q <= ma_d; mb_q <= mb_d;
  end

  assign stat_o.d_odd       = d_q[0];
  assign stat_o.e_zero      = (e_q == '0);
  assign stat_o.e_lsb       = e_q[0];
  assign stat_o.mul_last    = (bit_q == '0);
  assign stat_o.x_one       = (x_q == 64'd1);
  assign stat_o.x_m1        = (x_q == n_q - 64'd1);
  assign stat_o.small_comp  = (n_q <= 64'd1) || (n_q == 64'd4);
  assign stat_o.small_prime = (n_q == 64'd2) || (n_q == 64'd3);
  assign stat_o.base_ge_n   = (n_q <= base_w);
  assign stat_o.twos        = twos_q;

endmodule

FILE: sv/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// mrpt_ctrl
// Sequencer: splits n-1, runs square-and-multiply per base, then the
// squaring chain, and raises the verdict.
// ----------------------------------------------------------------------------
module mrpt_ctrl #(
  parameter int unsigned NUM_WITNESS_BASES = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mrpt_pkg::stat_t stat_i,
  output mrpt_pkg::ctrl_t ctrl_o,
  output logic            busy_o,
  output logic            done_o,
  output logic            prime_flag_o
);

  localparam int unsigned NB = (NUM_WITNESS_BASES > mrpt_pkg::MaxBases) ?
                               mrpt_pkg::MaxBases : NUM_WITNESS_BASES;

  typedef enum logic [3:0] {
    StIdle, StCheck, StSplit, StBase, StExp, StMulGo, StMul, StMulWb, StExpSh,
    StEval, StSq, StSqEval, StDone
  } state_e;

  state_e state_q;
  logic [mrpt_pkg::BaseIdxW-1:0] idx_q;
  logic [mrpt_pkg::TwosW-1:0] k_q;
  mrpt_pkg::sel_e sel_q;
  logic busy_q, done_q, flag_q;

  always_comb begin
    ctrl_o.cmd = mrpt_pkg::CmdNone;
    ctrl_o.sel = sel_q;
    ctrl_o.base_idx = idx_q;
    unique case (state_q)
      StIdle:  if (start_i) ctrl_o.cmd = mrpt_pkg::CmdLoad;
      StSplit: if (!stat_i.d_odd) ctrl_o.cmd = mrpt_pkg::CmdShift;
      StBase:  ctrl_o.cmd = mrpt_pkg::CmdInitBase;
      StMulGo: ctrl_o.cmd = mrpt_pkg::CmdMulStart;
      StMul:   ctrl_o.cmd = mrpt_pkg::CmdMulStep;
      StMulWb: ctrl_o.cmd = mrpt_pkg::CmdMulDone;
      StExpSh: ctrl_o.cmd = mrpt_pkg::CmdExpShift;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; idx_q <= '0; k_q <= '0; sel_q <= mrpt_pkg::SelXB;
      busy_q <= 1'b0; done_q <= 1'b0; flag_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: if (start_i) begin
          busy_q <= 1'b1; state_q <= StCheck;
        end
        StCheck: begin
          idx_q <= '0;
          if (stat_i.small_comp) begin
            flag_q <= 1'b0; state_q <= StDone;
          end else if (stat_i.small_prime) begin
            flag_q <= 1'b1; state_q <= StDone;
          end else state_q <= StSplit;
        end
        StSplit: if (stat_i.d_odd) state_q <= StBase;
        StBase: begin
          if (idx_q >= mrpt_pkg::BaseIdxW'(NB) || stat_i.base_ge_n) begin
            flag_q <= 1'b1; state_q <= StDone;
          end else state_q <= StExp;
        end
        StExp: begin
          // A set exponent bit multiplies x by b first; b is squared either way.
          if (stat_i.e_zero) state_q <= StEval;
          else begin
            sel_q <= stat_i.e_lsb ? mrpt_pkg::SelXB : mrpt_pkg::SelBB;
            state_q <= StMulGo;
          end
        end
        StMulGo: state_q <= StMul;
        StMul: if (stat_i.mul_last) state_q <= StMulWb;
        StMulWb: begin
          if (sel_q == mrpt_pkg::SelXB) begin
            sel_q <= mrpt_pkg::SelBB; state_q <= StMulGo;
          end else if (sel_q == mrpt_pkg::SelBB) state_q <= StExpSh;
          else state_q <= StSqEval;
        end
        StExpSh: state_q <= StExp;
        StEval: begin
          k_q <= 6'd1;
          if (stat_i.x_one || stat_i.x_m1) begin
            idx_q <= idx_q + 1'b1; state_q <= StBase;
          end else state_q <= StSq;
        end
        StSq: begin
          if (k_q >= stat_i.twos) begin
            flag_q <= 1'b0; state_q <= StDone;
          end else begin
            sel_q <= mrpt_pkg::SelXX; state_q <= StMulGo;
          end
        end
        StSqEval: begin
          k_q <= k_q + 1'b1;
          if (stat_i.x_one) begin
            flag_q <= 1'b0; state_q <= StDone;
          end else if (stat_i.x_m1) begin
            idx_q <= idx_q + 1'b1; state_q <= StBase;
          end else state_q <= StSq;
        end
        StDone: begin
          busy_q <= 1'b0; done_q <= 1'b1; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prime_flag_o = flag_q;

endmodule

FILE: sv/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// Deterministic 64-bit Miller-Rabin test with bases 2 through 37.
// ----------------------------------------------------------------------------
// Candidates below five get their verdict from the check state without any
// modular product; otherwise each tested base runs square-and-multiply over
// the exponent bits and then the squaring chain. One item at a time: busy is
// high from acceptance until done_o. Reset is asynchronous and returns the
// controller to idle. The receiver cannot stall done_o.
module miller_rabin_prime_test_64 #(
  parameter int unsigned NUM_WITNESS_BASES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] candidate_i,
  output logic        done_o,
  output logic        prime_flag_o
);

  mrpt_pkg::ctrl_t ctrl;
  mrpt_pkg::stat_t stat;

  mrpt_ctrl #(.NUM_WITNESS_BASES(NUM_WITNESS_BASES)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .ctrl_o(ctrl),
    .busy_o(busy), .done_o, .prime_flag_o
  );

  mrpt_datapath u_dp (
    .clk_i, .rst_ni, .candidate_i, .ctrl_i(ctrl), .stat_o(stat)
  );

  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy with done");

endmodule
